/* src/rsit_pkg.sv */
package rsit_pkg;

  localparam int DataW       = 32;
  localparam int PlaneW      = 3;
  localparam int NumPlanesDf = 7;
  localparam int QueueDepth  = 2;

  localparam logic signed [DataW-1:0] QMax = {1'b0, {(DataW-1){1'b1}}};
  localparam logic signed [DataW-1:0] QMin = {1'b1, {(DataW-1){1'b0}}};

  typedef struct packed {
    logic signed [DataW-1:0] slab_low;
    logic signed [DataW-1:0] slab_high;
    logic signed [DataW-1:0] origin_proj;
    logic signed [DataW-1:0] dir_proj;
    logic                    last_slab;
  } slab_t;

  typedef struct packed {
    logic                    hit;
    logic signed [DataW-1:0] entry_dist;
    logic signed [DataW-1:0] exit_dist;
    logic [PlaneW-1:0]       entry_plane;
  } result_t;

  // queue entry between front and back
  typedef struct packed {
    logic                    eval;
    logic [PlaneW-1:0]       plane;
    logic                    last_slab;
    logic                    neg_dir;
    logic                    zero_dir;
    logic signed [DataW:0]   num_lo;
    logic signed [DataW:0]   num_hi;
    logic signed [DataW-1:0] dir_proj;
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_UPD,
    BK_OUT
  } bk_state_t;

endpackage

/* src/rsit_if.sv */
interface rsit_slab_if;
  logic             valid;
  logic             ready;
  rsit_pkg::slab_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rsit_result_if;
  logic              valid;
  logic              ready;
  rsit_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* src/rsit_front.sv */
module rsit_front #(
  parameter int NumPlanes = rsit_pkg::NumPlanesDf
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  rsit_pkg::slab_t in_data,
  output logic            job_valid,
  input  logic            job_ready,
  output rsit_pkg::job_t  job_data
);
  localparam int PtrW = $clog2(rsit_pkg::QueueDepth);

  rsit_pkg::job_t q_mem [rsit_pkg::QueueDepth];
  logic [PtrW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [PtrW:0]   cnt_r, cnt_nxt;
  logic [rsit_pkg::PlaneW-1:0] count_r, count_nxt;
  rsit_pkg::job_t  job_in;
  logic push, pop;

  assign in_ready  = (cnt_r != rsit_pkg::QueueDepth[PtrW:0]);
  assign push      = in_valid && in_ready;
  assign job_valid = (cnt_r != '0);
  assign pop       = job_valid && job_ready;
  assign job_data  = q_mem[rd_r];

  always_comb begin
    job_in.eval      = ({1'b0, count_r} < NumPlanes[rsit_pkg::PlaneW:0]);
    job_in.plane     = count_r;
    job_in.last_slab = in_data.last_slab;
    job_in.neg_dir   = in_data.dir_proj[rsit_pkg::DataW-1];
    job_in.zero_dir  = (in_data.dir_proj == '0);
    job_in.num_lo    = {in_data.slab_low[rsit_pkg::DataW-1], in_data.slab_low}
                     - {in_data.origin_proj[rsit_pkg::DataW-1], in_data.origin_proj};
    job_in.num_hi    = {in_data.slab_high[rsit_pkg::DataW-1], in_data.slab_high}
                     - {in_data.origin_proj[rsit_pkg::DataW-1], in_data.origin_proj};
    job_in.dir_proj  = in_data.dir_proj;
  end

  always_comb begin
    count_nxt = count_r;
    if (push) begin
      if (in_data.last_slab) count_nxt = '0;
      else if (count_r != '1) count_nxt = count_r + 1'b1;
    end
    wr_nxt  = push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + {{PtrW{1'b0}}, push} - {{PtrW{1'b0}}, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= '0; rd_r <= '0; cnt_r <= '0; count_r <= '0;
    end else begin
      wr_r <= wr_nxt; rd_r <= rd_nxt; cnt_r <= cnt_nxt; count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_mem[wr_r] <= job_in;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= rsit_pkg::QueueDepth[PtrW:0]) else $error("queue overflow");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cnt_r != '0) else $error("pop from empty queue");
  a_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (push && in_data.last_slab) |=> count_r == '0) else $error("count not cleared");
endmodule

/* src/rsit_div.sv */
module rsit_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [rsit_pkg::DataW:0]   num,
  input  logic signed [rsit_pkg::DataW-1:0] den,
  output logic                              done,
  output logic signed [rsit_pkg::DataW-1:0] quot
);
  // dividend is num * 2^16, |num*2^16| < 2^49
  localparam int NW   = rsit_pkg::DataW + 17;
  localparam int CntW = $clog2(NW + 1);

  logic [NW-1:0] dvd_r, dvd_nxt, q_r, q_nxt;
  logic [rsit_pkg::DataW:0] rem_r, rem_nxt;
  logic [rsit_pkg::DataW-1:0] dmag_r;
  logic neg_r, busy_r, busy_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [rsit_pkg::DataW+1:0] trial;
  logic [NW-1:0] n_abs;
  logic signed [NW-1:0] n_ext, qs;

  assign n_ext = {num, 16'd0};
  assign n_abs = n_ext[NW-1] ? -n_ext : n_ext;
  assign trial = {rem_r, dvd_r[NW-1]} - {2'b00, dmag_r};

  always_comb begin
    dvd_nxt = dvd_r; q_nxt = q_r; rem_nxt = rem_r; cnt_nxt = cnt_r; busy_nxt = busy_r;
    if (busy_r) begin
      dvd_nxt = {dvd_r[NW-2:0], 1'b0};
      if (!trial[rsit_pkg::DataW+1]) begin
        rem_nxt = trial[rsit_pkg::DataW:0];
        q_nxt   = {q_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[rsit_pkg::DataW-1:0], dvd_r[NW-1]};
        q_nxt   = {q_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntW'(1)) busy_nxt = 1'b0;
    end else if (start) begin
      dvd_nxt = n_abs; q_nxt = '0; rem_nxt = '0;
      cnt_nxt = CntW'(NW); busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; cnt_r <= '0; done <= 1'b0;
    end else begin
      busy_r <= busy_nxt; cnt_r <= cnt_nxt;
      done   <= busy_r && (cnt_r == CntW'(1));
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt; q_r <= q_nxt; rem_r <= rem_nxt;
    if (!busy_r && start) begin
      dmag_r <= den[rsit_pkg::DataW-1] ? -den : den;
      neg_r  <= num[rsit_pkg::DataW] ^ den[rsit_pkg::DataW-1];
    end
  end

  // saturate the signed quotient
  assign qs = neg_r ? -$signed(q_r) : $signed(q_r);
  always_comb begin
    if (qs > $signed({{(NW-rsit_pkg::DataW){1'b0}}, rsit_pkg::QMax}))
      quot = rsit_pkg::QMax;
    else if (qs < $signed({{(NW-rsit_pkg::DataW){1'b1}}, rsit_pkg::QMin}))
      quot = rsit_pkg::QMin;
    else
      quot = qs[rsit_pkg::DataW-1:0];
  end
endmodule

/* src/rsit_back.sv */
module rsit_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              job_valid,
  output logic              job_ready,
  input  rsit_pkg::job_t    job_data,
  output logic              out_valid,
  input  logic              out_ready,
  output rsit_pkg::result_t out_data
);
  rsit_pkg::bk_state_t st_r, st_nxt;
  rsit_pkg::job_t job_r;
  logic signed [rsit_pkg::DataW-1:0] near_r, far_r, q_lo, q_hi, tn, tf, nn, nf;
  logic [rsit_pkg::PlaneW-1:0] plane_r;
  logic missed_r, d_lo, d_hi, div_start, take, skip;

  assign take = (st_r == rsit_pkg::BK_IDLE) && job_valid;
  assign skip = !job_data.eval || missed_r || job_data.zero_dir;
  assign div_start = take && !skip;

  rsit_div u_div_lo (.clk, .rst_n, .start(div_start), .num(job_data.num_lo),
                     .den(job_data.dir_proj), .done(d_lo), .quot(q_lo));
  rsit_div u_div_hi (.clk, .rst_n, .start(div_start), .num(job_data.num_hi),
                     .den(job_data.dir_proj), .done(d_hi), .quot(q_hi));

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      rsit_pkg::BK_IDLE: if (job_valid) begin
        if (!job_data.eval || missed_r) st_nxt = job_data.last_slab ?
                                                 rsit_pkg::BK_OUT : rsit_pkg::BK_IDLE;
        else if (job_data.zero_dir) st_nxt = rsit_pkg::BK_UPD;
        else st_nxt = rsit_pkg::BK_DIV;
      end
      rsit_pkg::BK_DIV:  if (d_lo) st_nxt = rsit_pkg::BK_UPD;
      rsit_pkg::BK_UPD:  st_nxt = job_r.last_slab ? rsit_pkg::BK_OUT : rsit_pkg::BK_IDLE;
      rsit_pkg::BK_OUT:  if (out_ready) st_nxt = rsit_pkg::BK_IDLE;
      default:           st_nxt = rsit_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    job_ready = (st_r == rsit_pkg::BK_IDLE);
    out_valid = (st_r == rsit_pkg::BK_OUT);
    out_data.hit         = !missed_r;
    out_data.entry_dist  = near_r;
    out_data.exit_dist   = far_r;
    out_data.entry_plane = plane_r;
  end

  always_comb begin
    if (job_r.zero_dir) begin
      tn = job_r.num_lo[rsit_pkg::DataW] ? rsit_pkg::QMin : rsit_pkg::QMax;
      tf = job_r.num_hi[rsit_pkg::DataW] ? rsit_pkg::QMin : rsit_pkg::QMax;
    end else if (job_r.neg_dir) begin
      tn = q_hi; tf = q_lo;
    end else begin
      tn = q_lo; tf = q_hi;
    end
    nn = (tn > near_r) ? tn : near_r;
    nf = (tf < far_r) ? tf : far_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= rsit_pkg::BK_IDLE;
      near_r <= rsit_pkg::QMin; far_r <= rsit_pkg::QMax;
      plane_r <= '0; missed_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == rsit_pkg::BK_UPD) begin
        near_r <= nn; far_r <= nf;
        if (tn > near_r) plane_r <= job_r.plane;
        if (nn > nf) missed_r <= 1'b1;
      end
      if (st_r == rsit_pkg::BK_OUT && out_ready) begin
        near_r <= rsit_pkg::QMin; far_r <= rsit_pkg::QMax;
        plane_r <= '0; missed_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) job_r <= job_data;
  end

  a_div_pair: assert property (@(posedge clk) disable iff (!rst_n)
    d_lo == d_hi) else $error("dividers out of step");
  a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    d_lo |-> st_r == rsit_pkg::BK_DIV) else $error("quotient outside divide state");
  a_out_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready) |=> (near_r == rsit_pkg::QMin && !missed_r))
    else $error("accumulators not cleared");
endmodule

/* src/ray_slab_interval_test_core.sv */
// Channel  | Dir | Payload                                           | Handshake
// in_      | in  | slab_low, slab_high, origin_proj, dir_proj, last  | valid/ready
// out_     | out | hit, entry_dist, exit_dist, entry_plane           | valid/ready
//
// An evaluated slab passes through dispatch, the two radix-2 dividers running
// in parallel (one iteration per quotient bit, then a done flag) and
// compare/update in the back end. Skipped slabs (after a miss or beyond
// NumPlanes) return straight to idle; zero direction slabs skip the dividers and
// go to update. After the last slab the result is held until out_ready is high.
// Reset is synchronous, active low, and clears the accumulators at once.
// A two-entry queue lets the front accept slabs while the back divides or
// waits on out_ready.
module ray_slab_interval_test_core #(
  parameter int NumPlanes = rsit_pkg::NumPlanesDf
) (
  input logic         clk,
  input logic         rst_n,
  rsit_slab_if.sink   in_ch,
  rsit_result_if.source out_ch
);
  logic           job_valid, job_ready;
  rsit_pkg::job_t job_data;

  // classify slabs and form exact differences
  rsit_front #(.NumPlanes(NumPlanes)) u_front (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .job_valid, .job_ready, .job_data
  );

  // divide, swap, update the interval, report
  rsit_back u_back (
    .clk, .rst_n,
    .job_valid, .job_ready, .job_data,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
  );
endmodule

/* dv/ray_slab_interval_test_core_tb.sv */
`timescale 1ns / 100ps

module ray_slab_interval_test_core_tb;

  localparam int NumItems = 700;
  localparam int StallLimit = 20000;

  // Interval accumulator for one ray, plus the queue of expected ray results.
  class interval_board;
    logic signed [rsit_pkg::DataW-1:0] near_acc;
    logic signed [rsit_pkg::DataW-1:0] far_acc;
    logic [rsit_pkg::PlaneW-1:0]       best_plane;
    int                                slab_count;
    bit                                missed;
    rsit_pkg::result_t                 ray_results[$];
    int                                errors;

    function void clear_ray();
      near_acc   = rsit_pkg::QMin;
      far_acc    = rsit_pkg::QMax;
      best_plane = '0;
      slab_count = 0;
      missed     = 1'b0;
    endfunction

    // Q16.16 quotient with truncation toward zero and saturation.
    function logic signed [rsit_pkg::DataW-1:0] slab_param(
        logic signed [rsit_pkg::DataW-1:0] ofs,
        logic signed [rsit_pkg::DataW-1:0] org,
        logic signed [rsit_pkg::DataW-1:0] dir);
      longint num;
      longint q;
      num = longint'(ofs) - longint'(org);
      if (dir == 0) return (num < 0) ? rsit_pkg::QMin : rsit_pkg::QMax;
      q = (num * 65536) / longint'(dir);
      if (q > longint'(rsit_pkg::QMax)) return rsit_pkg::QMax;
      if (q < longint'(rsit_pkg::QMin)) return rsit_pkg::QMin;
      return q[rsit_pkg::DataW-1:0];
    endfunction

    function void note_slab(rsit_pkg::slab_t s);
      logic signed [rsit_pkg::DataW-1:0] tn, tf, t;
      rsit_pkg::result_t r;
      if (!missed && slab_count < rsit_pkg::NumPlanesDf) begin
        tn = slab_param(s.slab_low, s.origin_proj, s.dir_proj);
        tf = slab_param(s.slab_high, s.origin_proj, s.dir_proj);
        if (s.dir_proj < 0) begin
          t = tn; tn = tf; tf = t;
        end
        if (tn > near_acc) begin
          near_acc   = tn;
          best_plane = slab_count[rsit_pkg::PlaneW-1:0];
        end
        if (tf < far_acc) far_acc = tf;
        if (near_acc > far_acc) missed = 1'b1;
      end
      if (slab_count < 7) slab_count++;
      if (s.last_slab) begin
        r.hit         = !missed;
        r.entry_dist  = near_acc;
        r.exit_dist   = far_acc;
        r.entry_plane = best_plane;
        ray_results.push_back(r);
        clear_ray();
      end
    endfunction

    task report(string what, longint got, longint want);
      $display("ERROR %0t: %s got %0h expected %0h", $time, what, got, want);
      errors++;
    endtask

    task check_result(rsit_pkg::result_t r);
      rsit_pkg::result_t e;
      if (ray_results.size() == 0) begin
        report("unexpected result", 0, 0);
        return;
      end
      e = ray_results.pop_front();
      if (r.hit != e.hit) report("hit", r.hit, e.hit);
      if (r.entry_dist != e.entry_dist) report("entry_dist", r.entry_dist, e.entry_dist);
      if (r.exit_dist != e.exit_dist) report("exit_dist", r.exit_dist, e.exit_dist);
      if (r.entry_plane != e.entry_plane)
        report("entry_plane", r.entry_plane, e.entry_plane);
    endtask
  endclass

  logic clk;
  logic rst_n;
  rsit_slab_if   slab_ch ();
  rsit_result_if ray_ch ();

  ray_slab_interval_test_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (slab_ch.sink),
    .out_ch (ray_ch.source)
  );

  interval_board     board;
  rsit_pkg::slab_t   slab_list[$];
  int                idle_cycles = 0;

  always begin
    clk = 1'b0; #2;
    clk = 1'b1; #2;
  end

  // Watch both channels: score every transaction and count dead cycles.
  always @(posedge clk) begin
    if (rst_n) begin
      if (slab_ch.valid && slab_ch.ready) board.note_slab(slab_ch.data);
      if (ray_ch.valid && ray_ch.ready) board.check_result(ray_ch.data);
      if ((slab_ch.valid && slab_ch.ready) || (ray_ch.valid && ray_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= StallLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Build a random value biased toward the edges of Q16.16.
  function automatic logic [rsit_pkg::DataW-1:0] pick_q();
    case ($urandom_range(0, 7))
      0: return rsit_pkg::QMax;
      1: return rsit_pkg::QMin;
      2: return '0;
      3: return $urandom_range(0, 8) << 16;
      4: return -($urandom_range(0, 8) << 16);
      5: return $signed($urandom_range(0, 20'hFFFFF)) - 32'sh80000;
      default: return $urandom();
    endcase
  endfunction

  function automatic rsit_pkg::slab_t rand_slab(bit last);
    rsit_pkg::slab_t s;
    logic signed [rsit_pkg::DataW-1:0] a, b;
    a = pick_q();
    b = pick_q();
    // Keep most slabs ordered so that rays often hit.
    if ($urandom_range(0, 3) != 0 && a > b) begin
      s.slab_low = b; s.slab_high = a;
    end else begin
      s.slab_low = a; s.slab_high = b;
    end
    s.origin_proj = ($urandom_range(0, 3) == 0) ? pick_q() : 32'($signed(
                    $urandom_range(0, 20'hFFFFF)) - 32'sh80000);
    s.dir_proj    = pick_q();
    s.last_slab   = last;
    return s;
  endfunction

  task build_stimulus();
    rsit_pkg::slab_t s;
    int n;
    // Directed: extremes, zero direction, swap, miss, too many slabs, empty ray.
    s = '{rsit_pkg::QMax, rsit_pkg::QMax, rsit_pkg::QMin, 32'sh0001_0000, 1'b1};
    slab_list.push_back(s);
    s = '{rsit_pkg::QMin, rsit_pkg::QMin, rsit_pkg::QMax, 32'sh0001_0000, 1'b1};
    slab_list.push_back(s);
    s = '{rsit_pkg::QMin, rsit_pkg::QMax, 32'sh0, 32'sh0, 1'b1}; slab_list.push_back(s);
    s = '{32'sh0, 32'sh0, 32'sh0, 32'sh0, 1'b1};    slab_list.push_back(s);
    s = '{32'sh0001_0000, 32'sh0002_0000, 0, -32'sh0001_0000, 1'b0}; slab_list.push_back(s);
    s = '{32'sh0001_0000, 32'sh0002_0000, 0, 32'sh0001_0000, 1'b1};  slab_list.push_back(s);
    s = '{32'sh0005_0000, 32'sh0006_0000, 0, 32'sh0001_0000, 1'b0};  slab_list.push_back(s);
    s = '{32'sh0001_0000, 32'sh0002_0000, 0, 32'sh0001_0000, 1'b0};  slab_list.push_back(s);
    s = '{32'sh0005_0000, 32'sh0006_0000, 0, 32'sh0001_0000, 1'b1};  slab_list.push_back(s);
    for (int i = 0; i < 10; i++) begin
      s = '{32'sh0001_0000 * i, 32'sh0020_0000, 0, 32'sh0001_0000, i == 9};
      slab_list.push_back(s);
    end
    s = '{rsit_pkg::QMax, rsit_pkg::QMin, 32'sh1, 32'sh1, 1'b1}; slab_list.push_back(s);
    s = '{32'shFFFF_FFFF, 32'sh1, 32'sh0, rsit_pkg::QMin, 1'b1}; slab_list.push_back(s);
    // Random rays of 1 to 10 slabs.
    while (slab_list.size() < NumItems) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 10) : $urandom_range(1, 7);
      for (int i = 0; i < n; i++) slab_list.push_back(rand_slab(i == n - 1));
    end
  endtask

  task drive_slabs();
    int gap;
    int burst;
    while (slab_list.size() > 0) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && slab_list.size() > 0) begin
        slab_ch.valid <= 1'b1;
        slab_ch.data  <= slab_list[0];
        @(posedge clk);
        while (!slab_ch.ready) @(posedge clk);
        void'(slab_list.pop_front());
        burst--;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60);
      if (gap > 0) begin
        slab_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    slab_ch.valid <= 1'b0;
  endtask

  // Receiver: a long hold-off early on, then a stall pattern of its own.
  initial begin
    int phase;
    ray_ch.ready = 1'b0;
    @(posedge clk iff rst_n);
    repeat (2000) @(posedge clk);
    forever begin
      phase = $urandom_range(0, 3);
      repeat ($urandom_range(1, 30)) begin
        ray_ch.ready <= (phase == 0) ? 1'b1 : ($urandom_range(0, phase) == 0);
        @(posedge clk);
      end
    end
  end

  initial begin
    board = new();
    board.clear_ray();
    board.errors = 0;
    rst_n = 1'b0;
    slab_ch.valid = 1'b0;
    slab_ch.data  = '0;
    build_stimulus();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    drive_slabs();
    // Let the monitor score the final transaction before draining.
    @(posedge clk);
    while (board.ray_results.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (board.errors == 0 && board.ray_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/rsit_pkg.sv
src/rsit_if.sv
src/rsit_front.sv
src/rsit_div.sv
src/rsit_back.sv
src/ray_slab_interval_test_core.sv
dv/ray_slab_interval_test_core_tb.sv
